### rtl/core/its_pkg.sv
// its_pkg: shared types, reset constants and helpers for the in-band tag stripper
// used by its_step, its_outbuf and inband_tag_stripper_top; no dependencies
`timescale 1ns / 1ps

package its_pkg;

  // register reset values
  localparam logic [31:0] FP_RESET   = 32'h81828384;
  localparam logic [7:0]  OPEN_RESET = 8'h7B;

  // lookahead window and result burst sizes
  localparam int WIN_DEPTH = 4;
  localparam int MAX_RES   = 5;
  localparam int FILL_W    = 3;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FINGERPRINT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_CHAR   = 2'd1;

  // stream state carried between items
  typedef struct packed {
    logic [WIN_DEPTH-1:0][7:0] win;
    logic [FILL_W-1:0]         fill;
    logic                      in_tag;
    logic                      skip;
  } its_state_t;

  // result burst produced by one item
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [FILL_W-1:0]       cnt;
    logic                    has;
    logic                    fin;
  } its_list_t;

  // fingerprint compare, lowest byte first
  function automatic logic fp_match(logic [31:0] fp, logic [7:0] a, logic [7:0] b,
                                    logic [7:0] c, logic [7:0] d);
    return ({d, c, b, a} == fp);
  endfunction

endpackage

### rtl/core/its_step.sv
// its_step: next-state and result burst logic for one byte of the stream
// depends on its_pkg
`timescale 1ns / 1ps

module its_step (
  input  its_pkg::its_state_t st_i,
  input  logic [31:0]         fp_i,
  input  logic [7:0]          open_i,
  input  logic [7:0]          byte_i,
  input  logic                fin_i,
  output its_pkg::its_state_t st_o,
  output its_pkg::its_list_t  list_o
);

  its_pkg::its_state_t ns;
  logic                e0;
  logic                flush;
  logic [2:0]          cnt;

  // window update for one byte
  always_comb begin
    ns = st_i;
    e0 = 1'b0;
    if (st_i.skip) begin
      ns.skip = 1'b0;
    end else if (st_i.in_tag) begin
      if (st_i.fill == 3'd3) begin
        if (its_pkg::fp_match(fp_i, st_i.win[0], st_i.win[1], st_i.win[2], byte_i)) begin
          ns.in_tag = 1'b0;
          ns.skip   = 1'b1;
          ns.win    = '0;
          ns.fill   = '0;
        end else begin
          // keep the three newest tag bytes
          ns.win[0] = st_i.win[1];
          ns.win[1] = st_i.win[2];
          ns.win[2] = byte_i;
          ns.win[3] = 8'd0;
          ns.fill   = 3'd3;
        end
      end else begin
        ns.win[st_i.fill[1:0]] = byte_i;
        ns.fill = st_i.fill + 3'd1;
      end
    end else if (st_i.fill == 3'd4) begin
      if ((st_i.win[0] == open_i) &&
          its_pkg::fp_match(fp_i, st_i.win[1], st_i.win[2], st_i.win[3], byte_i)) begin
        ns.in_tag = 1'b1;
        ns.win    = '0;
        ns.fill   = '0;
      end else begin
        // oldest byte is classified as payload
        e0        = 1'b1;
        ns.win[0] = st_i.win[1];
        ns.win[1] = st_i.win[2];
        ns.win[2] = st_i.win[3];
        ns.win[3] = byte_i;
      end
    end else begin
      ns.win[st_i.fill[1:0]] = byte_i;
      ns.fill = st_i.fill + 3'd1;
    end
  end

  // result burst: shifted-out byte, then flushed window at end of stream
  always_comb begin
    flush = fin_i && !ns.in_tag && !ns.skip;
    cnt   = {2'b00, e0} + (flush ? ns.fill : 3'd0);
    list_o.bytes[0] = e0 ? st_i.win[0] : ns.win[0];
    for (int i = 1; i < its_pkg::WIN_DEPTH; i++) begin
      list_o.bytes[i] = e0 ? ns.win[i-1] : ns.win[i];
    end
    list_o.bytes[its_pkg::MAX_RES-1] = e0 ? ns.win[its_pkg::WIN_DEPTH-1] : 8'd0;
    list_o.cnt = cnt;
    list_o.has = 1'b1;
    list_o.fin = fin_i;
    // end marker alone when the last item yields no byte
    if (fin_i && (cnt == 3'd0)) begin
      list_o.bytes = '0;
      list_o.cnt   = 3'd1;
      list_o.has   = 1'b0;
    end
  end

  // end of stream returns to the reset state
  always_comb begin
    st_o = ns;
    if (fin_i) begin
      st_o = '0;
    end
  end

endmodule

### rtl/core/its_outbuf.sv
// its_outbuf: result register holding one burst of up to five items, drained one per cycle
// while m_axis_tready is high; depends on its_pkg
`timescale 1ns / 1ps

module its_outbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  its_pkg::its_list_t list_i,
  output logic               free_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,
  output logic               m_axis_tuser,
  output logic               m_axis_tlast
);

  logic [its_pkg::MAX_RES-1:0][7:0] ent_q;
  logic [2:0]                       left_q, left_d;
  logic [2:0]                       rd_q, rd_d;
  logic                             has_q;
  logic                             end_q;
  logic                             pop;

  assign pop    = m_axis_tvalid && m_axis_tready;
  assign free_o = (left_q == 3'd0) || ((left_q == 3'd1) && m_axis_tready);

  // burst counters
  always_comb begin
    left_d = left_q;
    rd_d   = rd_q;
    if (load_i) begin
      left_d = list_i.cnt;
      rd_d   = 3'd0;
    end else if (pop) begin
      left_d = left_q - 3'd1;
      rd_d   = rd_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 3'd0;
      rd_q   <= 3'd0;
    end else begin
      left_q <= left_d;
      rd_q   <= rd_d;
    end
  end

  // burst payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= list_i.bytes;
      has_q <= list_i.has;
      end_q <= list_i.fin;
    end
  end

  assign m_axis_tvalid = (left_q != 3'd0);
  assign m_axis_tdata  = ent_q[rd_q];
  assign m_axis_tuser  = has_q;
  assign m_axis_tlast  = end_q && (left_q == 3'd1);

endmodule

### rtl/core/inband_tag_stripper_top.sv
// inband_tag_stripper_top: top level of the in-band tag stripper
// depends on its_pkg, its_step, its_outbuf
`timescale 1ns / 1ps

// Usage
//   s_axis: raw byte stream, tdata = data_byte, tlast = final_byte (end of stream).
//   m_axis: payload bytes with tags removed, tdata = out_byte, tuser = has_byte,
//     tlast = stream_end. An item with tuser low is a bare end marker with tdata zero.
//   cfg: write channel, index 0 = fingerprint, index 1 = open byte, other indexes
//     ignored; always ready; write only while the block is idle.
// Path: an accepted byte is held in the input register until the result register frees,
//   then its results are loaded into the result register, from which m_axis presents
//   them. Payload bytes lag the input by up to four bytes of lookahead.
// Throughput: one byte per cycle while m_axis is ready and each byte yields at most one
//   result. The end-of-stream byte yields up to five results, drained one per cycle from
//   the result register while m_axis is ready; the next byte is processed once that
//   burst is down to its last item.
// Reset: window empty, outside any tag, fingerprint 0x81828384, open byte 0x7B.
// Stall: a stalled m_axis holds its item; one more input byte is taken into the
//   input register, then s_axis_tready drops until the result register frees.

module inband_tag_stripper_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tlast,   // final_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [7:0] out_byte
  output logic                          m_axis_tuser,   // [0] has_byte
  output logic                          m_axis_tlast,   // stream_end
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [its_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  logic                in_vld_q, in_vld_d;
  logic [7:0]          in_byte_q;
  logic                in_fin_q;
  logic                proc;
  logic                free;
  logic                s_fire;
  its_pkg::its_state_t st_q, st_d;
  its_pkg::its_list_t  list;
  logic [31:0]         fp_q;
  logic [7:0]          open_q;

  assign cfg_ready_o   = 1'b1;
  assign proc          = in_vld_q && free;
  assign s_axis_tready = !in_vld_q || proc;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q   <= its_pkg::FP_RESET;
      open_q <= its_pkg::OPEN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        its_pkg::CFG_FINGERPRINT: fp_q   <= cfg_data_i;
        its_pkg::CFG_OPEN_CHAR:   open_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_comb begin
    in_vld_d = in_vld_q;
    if (s_fire) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata;
      in_fin_q  <= s_axis_tlast;
    end
  end

  // stream state
  its_step u_step (
    .st_i   (st_q),
    .fp_i   (fp_q),
    .open_i (open_q),
    .byte_i (in_byte_q),
    .fin_i  (in_fin_q),
    .st_o   (st_d),
    .list_o (list)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (proc) begin
      st_q <= st_d;
    end
  end

  // result register
  its_outbuf u_outbuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (proc),
    .list_i        (list),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### rtl/core/its_checker.sv
// its_checker: port-level assertions for inband_tag_stripper_top, bound to the top level
// depends on inband_tag_stripper_top
`timescale 1ns / 1ps

module its_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result item changed");

  // bare end marker is the last item and carries a zero byte
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0))
    else $error("end marker malformed");

  // input back-pressure only while results are pending
  a_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // a stalled result keeps input blocked until the receiver takes an item
  a_bp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && !m_axis_tready |=> !s_axis_tready || m_axis_tready)
    else $error("input released while output stalled");

endmodule

bind inband_tag_stripper_top its_checker u_its_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
